>>> hw/rtl/lir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared widths, register map, reset values, types and the sample normalizer.
// ----------------------------------------------------------------------------
package lir_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS       = 13;
   localparam int GAIN_FRAC_BITS  = 24;
   localparam int DEF_MAX_OUTPUTS = 16;

   localparam int SAMP_W = 16;
   localparam int OUT_W  = 20;
   localparam int POS_W  = 18;
   localparam int GAIN_W = 29;
   localparam int MUTE_W = 25;
   localparam int STEP_W = 17;
   localparam int CH_W   = 2;

   // Pipeline depth of one lane, from issue to registered result.
   localparam int LANE_LAT = 4;

   // Configuration port.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;

   localparam logic [IDX_W-1:0] REG_GAIN       = 3'd0;
   localparam logic [IDX_W-1:0] REG_MUTE_LEVEL = 3'd1;
   localparam logic [IDX_W-1:0] REG_STEP_SIZE  = 3'd2;
   localparam logic [IDX_W-1:0] REG_FORMAT     = 3'd3;
   localparam logic [IDX_W-1:0] REG_SRC_CH     = 3'd4;
   localparam logic [IDX_W-1:0] REG_OUT_CH     = 3'd5;

   localparam logic            FMT_U8  = 1'b0;
   localparam logic            FMT_S16 = 1'b1;
   localparam logic [CH_W-1:0] CH_MONO   = 2'd1;
   localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

   typedef logic signed [SAMP_W-1:0] samp_type;
   typedef logic signed [OUT_W-1:0]  out_type;
   typedef logic [FRAC_BITS:0]       frac_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [GAIN_W-1:0]        gain_type;
   typedef logic [MUTE_W-1:0]        mute_type;
   typedef logic [STEP_W-1:0]        step_type;

   localparam gain_type UNITY_GAIN = gain_type'(64'd1 << GAIN_FRAC_BITS);
   localparam gain_type GAIN_LIMIT = gain_type'(64'd1 << (GAIN_FRAC_BITS + 4));
   localparam pos_type  POS_ONE    = pos_type'(64'd1 << FRAC_BITS);

   localparam gain_type RST_GAIN   = UNITY_GAIN;
   localparam mute_type RST_MUTE   = mute_type'(512);
   localparam step_type RST_STEP   = step_type'(8192);
   localparam logic     RST_FORMAT = FMT_S16;

   // Gain decision shared by both lanes and the output stage.
   typedef struct packed {
      logic unity;
      logic mute;
   } gctl_type;

   // Control that travels alongside the lane data.
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   // One output position handed from the sequencer to the lanes.
   typedef struct packed {
      tag_type  tag;
      frac_type frac;
      samp_type prev_l;
      samp_type new_l;
      samp_type prev_r;
      samp_type new_r;
   } issue_type;

   // Unsigned 8-bit samples are recentered and moved to the top byte.
   function automatic samp_type normalize(input logic [SAMP_W-1:0] raw, input logic fmt);
      samp_type s;
      if (fmt == FMT_U8) begin
         s = {~raw[7], raw[6:0], 8'h00};
      end else begin
         s = raw;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lir_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Resampler position sequencer
// Holds the previous frame and the fractional position, and steps through the
// output positions of one source frame, one position per cycle while adv is high.
// ----------------------------------------------------------------------------
module lir_seq
   import lir_pkg::*;
#(
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      accept,
   input  logic      restart,
   input  samp_type  frame_l,
   input  samp_type  frame_r,
   input  step_type  step_size,
   output logic      busy,
   output issue_type issue
);

   localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);
   localparam int MIN_STEP_I = ((1 << FRAC_BITS) + MAX_OUTPUTS - 1) / MAX_OUTPUTS;
   localparam step_type   MIN_STEP = step_type'(MIN_STEP_I);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OUTPUTS);

   logic             busy_ff, busy_in;
   pos_type          pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   samp_type         prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   samp_type         new_l_ff, new_r_ff;

   step_type step_eff;
   pos_type  pos_next;
   logic     in_range, do_out, last;

   // Step is raised so that one frame never yields more than MAX_OUTPUTS results.
   assign step_eff = (step_size < MIN_STEP) ? MIN_STEP : step_size;
   assign pos_next = pos_ff + pos_type'(step_eff);
   assign in_range = (pos_ff <= POS_ONE) && (cnt_ff < CNT_MAX);
   assign do_out   = busy_ff && in_range;
   assign last     = (pos_next > POS_ONE) || ((cnt_ff + 1'b1) == CNT_MAX);

   // Issue toward the lanes.
   always_comb begin
      issue.tag.valid = do_out && adv;
      issue.tag.last  = last;
      issue.frac      = pos_ff[FRAC_BITS:0];
      issue.prev_l    = prev_l_ff;
      issue.new_l     = new_l_ff;
      issue.prev_r    = prev_r_ff;
      issue.new_r     = new_r_ff;
   end

   assign busy = busy_ff;

   // Next state: accept a frame, step positions, then close the frame.
   always_comb begin
      busy_in   = busy_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         if (restart) begin
            prev_l_in = '0;
            prev_r_in = '0;
            pos_in    = POS_ONE;
         end
      end else if (do_out) begin
         if (adv) begin
            pos_in = pos_next;
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (busy_ff) begin
         // Rebase by a frame (else set to one step); the new frame becomes history.
         pos_in    = (pos_ff > POS_ONE) ? (pos_ff - POS_ONE) : pos_type'(step_eff);
         prev_l_in = new_l_ff;
         prev_r_in = new_r_ff;
         busy_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pos_ff    <= POS_ONE;
         cnt_ff    <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
      end
   end

   // Incoming frame, already normalized and mapped.
   always_ff @(posedge clock) begin
      if (accept) begin
         new_l_ff <= frame_l;
         new_r_ff <= frame_r;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/lir_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Resampler channel lane
// Four-stage pipeline: interpolation product, interpolated sample, gain
// product, then shift, saturation and unity or mute selection.
// ----------------------------------------------------------------------------
module lir_lane
   import lir_pkg::*;
(
   input  logic     clock,
   input  logic     adv,
   input  samp_type prev_s,
   input  samp_type new_s,
   input  frac_type frac,
   input  gain_type gain,
   input  gctl_type gctl,
   output out_type  result
);

   localparam int DIFF_W = SAMP_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_BITS + 2;
   localparam int MULT_W = SAMP_W + GAIN_W + 1;

   logic signed [DIFF_W-1:0]    diff;
   logic signed [FRAC_BITS+1:0] frac_s;
   logic signed [PROD_W-1:0]    prod_ff, prod_in, lerp_full;
   samp_type                    base_ff, samp_ff, samp_in, samp3_ff;
   logic signed [GAIN_W:0]      gain_s;
   logic signed [MULT_W-1:0]    mult_ff, mult_in, shifted;
   out_type                     result_ff, result_in, sat_val;
   logic                        fits;

   // Stage 1: difference times fraction.
   assign diff    = {new_s[SAMP_W-1], new_s} - {prev_s[SAMP_W-1], prev_s};
   assign frac_s  = {1'b0, frac};
   assign prod_in = diff * frac_s;

   // Stage 2: previous sample plus the floored fractional part.
   assign lerp_full = {{(PROD_W-SAMP_W){base_ff[SAMP_W-1]}}, base_ff}
                      + (prod_ff >>> FRAC_BITS);
   assign samp_in   = lerp_full[SAMP_W-1:0];

   // Stage 3: gain product.
   assign gain_s  = {1'b0, gain};
   assign mult_in = samp_ff * gain_s;

   // Stage 4: floor shift and saturation to the output width.
   assign shifted = mult_ff >>> GAIN_FRAC_BITS;
   assign fits    = (&shifted[MULT_W-1:OUT_W-1]) || !(|shifted[MULT_W-1:OUT_W-1]);
   always_comb begin
      if (fits) begin
         sat_val = shifted[OUT_W-1:0];
      end else if (shifted[MULT_W-1]) begin
         sat_val = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(OUT_W-1){1'b1}}};
      end
      if (gctl.unity) begin
         result_in = {{(OUT_W-SAMP_W){samp3_ff[SAMP_W-1]}}, samp3_ff};
      end else if (gctl.mute) begin
         result_in = '0;
      end else begin
         result_in = sat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         base_ff   <= prev_s;
         samp_ff   <= samp_in;
         mult_ff   <= mult_in;
         samp3_ff  <= samp_ff;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

>>> hw/rtl/lir_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Resampler output merge
// Delays the control tag alongside the lanes, joins both channel results into
// one response and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module lir_merge
   import lir_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tag_type              tag,
   input  out_type              lane_l,
   input  out_type              lane_r,
   input  gctl_type             gctl,
   input  logic                 mono_out,
   output logic                 adv,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*OUT_W-1:0]   rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   tag_type tag_ff [LANE_LAT];
   logic    valid_ff;
   out_type left_ff, right_ff;
   logic    written_ff, last_ff;

   // The whole pipeline moves whenever the output register is free or drained.
   assign adv = !valid_ff || rsp_tready;

   // Tag delay line matching the lane latency.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            tag_ff[i] <= '0;
         end
         valid_ff <= 1'b0;
      end else if (adv) begin
         tag_ff[0] <= tag;
         for (int i = 1; i < LANE_LAT; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         valid_ff <= tag_ff[LANE_LAT-1].valid;
      end
   end

   // Output payload; a mono output carries zero in the right channel.
   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff    <= lane_l;
         right_ff   <= mono_out ? '0 : lane_r;
         written_ff <= !gctl.mute;
         last_ff    <= tag_ff[LANE_LAT-1].last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tuser  = written_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

>>> hw/rtl/linear_interp_resampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Converts a stream of source frames into output frames by linear
// interpolation, with a gain stage and mono/stereo mapping.
// ----------------------------------------------------------------------------
// Each source request is normalized to signed 16 bits, mapped to the output
// channel layout and accepted while the sequencer is idle. The sequencer then
// emits one output position per cycle, while the output is not stalled, into
// two channel lanes; a frame produces 0 to MAX_OUTPUTS results, and the next
// request is accepted only once the sequencer has closed the current frame. A
// stalled output holds the whole pipeline. The final result caused by a frame
// carries tlast; tuser is low on results produced while the gain is muted. The
// user must write configuration through the register port only while no frame
// is busy; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_interp_resampler_top
   import lir_pkg::*;
#(
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
   input  logic                clock,
   input  logic                reset,
   // Source requests.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // raw_left [15:0], raw_right [31:16]
   input  logic                req_tuser,   // restart
   // Results.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [2*OUT_W-1:0]  rsp_tdata,   // out_left [19:0], out_right [39:20]
   output logic                rsp_tuser,   // written
   output logic                rsp_tlast,   // last_of_run
   // Register port.
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready
);

   gain_type        gain_ff;
   mute_type        mute_ff;
   step_type        step_ff;
   logic            fmt_ff;
   logic [CH_W-1:0] src_ch_ff, out_ch_ff;

   logic             wr_en;
   logic [IDX_W-1:0] reg_idx;
   logic             accept, busy, adv;
   logic             mono_src, mono_out;
   samp_type         norm_l, norm_r, src_r, frame_l, frame_r;
   logic signed [SAMP_W:0] mix_sum;
   gain_type         gain_eff;
   gctl_type         gctl;
   issue_type        issue;
   out_type          lane_l, lane_r;

   // Register port.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= RST_GAIN;
         mute_ff   <= RST_MUTE;
         step_ff   <= RST_STEP;
         fmt_ff    <= RST_FORMAT;
         src_ch_ff <= CH_STEREO;
         out_ch_ff <= CH_STEREO;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_GAIN:       gain_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_MUTE_LEVEL: mute_ff   <= csr_pwdata[MUTE_W-1:0];
            REG_STEP_SIZE:  step_ff   <= csr_pwdata[STEP_W-1:0];
            REG_FORMAT:     fmt_ff    <= csr_pwdata[0];
            REG_SRC_CH:     src_ch_ff <= csr_pwdata[CH_W-1:0];
            REG_OUT_CH:     out_ch_ff <= csr_pwdata[CH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GAIN:       csr_prdata = DATA_W'(gain_ff);
         REG_MUTE_LEVEL: csr_prdata = DATA_W'(mute_ff);
         REG_STEP_SIZE:  csr_prdata = DATA_W'(step_ff);
         REG_FORMAT:     csr_prdata = DATA_W'(fmt_ff);
         REG_SRC_CH:     csr_prdata = DATA_W'(src_ch_ff);
         REG_OUT_CH:     csr_prdata = DATA_W'(out_ch_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Input normalization and channel mapping; codes other than mono mean stereo.
   assign mono_src = (src_ch_ff == CH_MONO);
   assign mono_out = (out_ch_ff == CH_MONO);
   assign norm_l   = normalize(req_tdata[15:0], fmt_ff);
   assign norm_r   = normalize(req_tdata[31:16], fmt_ff);
   assign src_r    = mono_src ? norm_l : norm_r;
   assign mix_sum  = {norm_l[SAMP_W-1], norm_l} + {src_r[SAMP_W-1], src_r};
   assign frame_l  = mono_out ? mix_sum[SAMP_W:1] : norm_l;
   assign frame_r  = mono_out ? '0 : src_r;

   // No request is taken while reset is held.
   assign req_tready = !busy && !reset;
   assign accept     = req_tvalid && req_tready;

   // Gain is limited to 16x; unity passes through even below the mute level.
   assign gain_eff   = (gain_ff > GAIN_LIMIT) ? GAIN_LIMIT : gain_ff;
   assign gctl.unity = (gain_eff == UNITY_GAIN);
   assign gctl.mute  = !gctl.unity && (gain_eff < GAIN_W'(mute_ff));

   lir_seq #(
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .accept    (accept),
      .restart   (req_tuser),
      .frame_l   (frame_l),
      .frame_r   (frame_r),
      .step_size (step_ff),
      .busy      (busy),
      .issue     (issue)
   );

   lir_lane u_lane_l (
      .clock  (clock),
      .adv    (adv),
      .prev_s (issue.prev_l),
      .new_s  (issue.new_l),
      .frac   (issue.frac),
      .gain   (gain_eff),
      .gctl   (gctl),
      .result (lane_l)
   );

   lir_lane u_lane_r (
      .clock  (clock),
      .adv    (adv),
      .prev_s (issue.prev_r),
      .new_s  (issue.new_r),
      .frac   (issue.frac),
      .gain   (gain_eff),
      .gctl   (gctl),
      .result (lane_r)
   );

   lir_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .tag        (issue.tag),
      .lane_l     (lane_l),
      .lane_r     (lane_r),
      .gctl       (gctl),
      .mono_out   (mono_out),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> tb/tb_linear_interp_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler testbench
// Streams source frames into the resampler under random back-pressure on
// both sides. A shadow model of the interpolator, the gain stage and the
// channel mapping predicts every output frame, and each result is checked
// in order against those predictions. Register settings change between
// phases through the configuration port and are read back.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler_top;
   import lir_pkg::*;

   localparam int ONE_FRAME       = 1 << FRAC_BITS;
   localparam int MIN_STEP        = (ONE_FRAME + DEF_MAX_OUTPUTS - 1) / DEF_MAX_OUTPUTS;
   localparam int POS_MASK        = (1 << POS_W) - 1;
   localparam longint OUT_MAX     = (64'sd1 <<< (OUT_W - 1)) - 1;
   localparam longint OUT_MIN     = -(64'sd1 <<< (OUT_W - 1));
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT     = 40000;
   localparam int PHASE_ITEMS     = 50;
   localparam int RANDOM_PHASES   = 9;
   localparam int DIR_ROWS        = 44;

   // One output frame as the block reports it.
   typedef struct packed {
      out_type out_l;
      out_type out_r;
      logic    written;
      logic    last;
   } out_frame_type;

   typedef enum logic {
      ROW_FRAME,
      ROW_WRITE
   } row_kind_type;

   // One line of the directed table: a register write or a source frame.
   typedef struct packed {
      row_kind_type     kind;
      logic [IDX_W-1:0] reg_idx;
      logic [31:0]      value;
      logic [15:0]      raw_l;
      logic [15:0]      raw_r;
      logic             restart;
      logic             typed;
      out_type          exp_l;
      out_type          exp_r;
   } dir_row_type;

   // Frames right after reset run at unity gain and one output per frame, so
   // their results equal the normalized input and are written out here.
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h0000, 16'h0000, 1'b1, 1'b1, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h7FFF, 16'h8000, 1'b0, 1'b1, 20'sd32767, -20'sd32768},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h8000, 16'h7FFF, 1'b0, 1'b1, -20'sd32768, 20'sd32767},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'hFFFF, 16'h0001, 1'b0, 1'b1, -20'sd1, 20'sd1},
      '{ROW_WRITE, REG_STEP_SIZE, 32'd4096, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h1000, 16'hF000, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_FORMAT, 32'(FMT_U8), 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h12FF, 16'h3400, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'hAB80, 16'h0000, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h0000, 16'h00FF, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_SRC_CH, 32'(CH_MONO), 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h00FF, 16'hFFFF, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_FORMAT, 32'(FMT_S16), 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_SRC_CH, 32'(CH_STEREO), 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_OUT_CH, 32'(CH_MONO), 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h8000, 16'h8000, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_OUT_CH, 32'(CH_STEREO), 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_GAIN, 32'h0080_0000, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h0003, 16'hFFFD, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_GAIN, 32'h1FFF_FFFF, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_GAIN, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h1234, 16'h4321, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_MUTE_LEVEL, 32'h01FF_FFFF, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_GAIN, 32'h0100_0000, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h4000, 16'hC000, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_GAIN, 32'h00FF_FFFF, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h4000, 16'hC000, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_MUTE_LEVEL, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_STEP_SIZE, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_STEP_SIZE, 32'd65536, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h1111, 16'h2222, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h3333, 16'h4444, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h5555, 16'h6666, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_SRC_CH, 32'd0, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_OUT_CH, 32'd3, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h2468, 16'h9BDF, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_WRITE, REG_STEP_SIZE, 32'h1FFFF, 16'h0, 16'h0, 1'b0, 1'b0, 20'sd0, 20'sd0},
      '{ROW_FRAME, REG_GAIN, 32'h0, 16'h0F0F, 16'hF0F0, 1'b1, 1'b0, 20'sd0, 20'sd0}
   };

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [31:0]         req_tdata;   // raw_left [15:0], raw_right [31:16]
   logic                req_tuser;   // restart
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [2*OUT_W-1:0]  rsp_tdata;   // out_left [19:0], out_right [39:20]
   logic                rsp_tuser;   // written
   logic                rsp_tlast;   // last_of_run
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   linear_interp_resampler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the registers and of the interpolator history.
   gain_type         cfg_gain;
   mute_type         cfg_mute;
   step_type         cfg_step;
   logic             cfg_fmt;
   logic [CH_W-1:0]  cfg_src;
   logic [CH_W-1:0]  cfg_out;
   int               hist_l;
   int               hist_r;
   int               src_pos;

   out_frame_type    burst [DEF_MAX_OUTPUTS];
   out_frame_type    due_outputs [$];

   int               n_requests;
   int               n_results;
   int               n_muted;
   int               n_writes;
   int               n_errors;
   bit               source_eager;
   bit               hold_off_request;

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h7FFF;
      if (r == 1) return 16'h8000;
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // Raw sample to signed 16-bit; u8 is recentered into the top byte.
   function automatic int to_s16(input logic [15:0] raw, input logic fmt);
      if (fmt == FMT_U8) return (int'(raw[7:0]) - 128) * 256;
      return int'($signed(raw));
   endfunction

   function automatic int lerp(input int a, input int b, input int frac);
      longint d;
      d = longint'(b) - longint'(a);
      return a + int'((d * longint'(frac)) >>> FRAC_BITS);
   endfunction

   function automatic out_type apply_gain(input int s, input gain_type g, output logic wr);
      longint v;
      wr = 1'b1;
      if (g == UNITY_GAIN) begin
         v = s;
      end else if (g < cfg_mute) begin
         wr = 1'b0;
         v = 0;
      end else begin
         v = (longint'(s) * longint'({35'd0, g})) >>> GAIN_FRAC_BITS;
         if (v > OUT_MAX) v = OUT_MAX;
         if (v < OUT_MIN) v = OUT_MIN;
      end
      return out_type'(v);
   endfunction

   // Works out every output frame that the new source frame produces.
   task automatic expand_frame(input logic [15:0] raw_l, input logic [15:0] raw_r,
                               input logic restart, output int n);
      int       l, r, nl, nr, p, step;
      gain_type g;
      logic     wr_l, wr_r;
      n = 0;
      if (restart) begin
         hist_l = 0;
         hist_r = 0;
         src_pos = ONE_FRAME;
      end
      l = to_s16(raw_l, cfg_fmt);
      r = (cfg_src == CH_MONO) ? l : to_s16(raw_r, cfg_fmt);
      if (cfg_out == CH_MONO) begin
         nl = (l + r) >>> 1;
         nr = 0;
      end else begin
         nl = l;
         nr = r;
      end
      g = (cfg_gain > GAIN_LIMIT) ? GAIN_LIMIT : cfg_gain;
      step = (int'(cfg_step) < MIN_STEP) ? MIN_STEP : int'(cfg_step);
      p = src_pos & POS_MASK;
      while (p <= ONE_FRAME && n < DEF_MAX_OUTPUTS) begin
         burst[n].out_l = apply_gain(lerp(hist_l, nl, p), g, wr_l);
         if (cfg_out == CH_MONO) begin
            burst[n].out_r = '0;
         end else begin
            burst[n].out_r = apply_gain(lerp(hist_r, nr, p), g, wr_r);
         end
         burst[n].written = wr_l;
         burst[n].last = 1'b0;
         p += step;
         n++;
      end
      if (n > 0) burst[n-1].last = 1'b1;
      src_pos = ((p > ONE_FRAME) ? (p - ONE_FRAME) : step) & POS_MASK;
      hist_l = nl;
      hist_r = nr;
   endtask

   // Offers one source frame and records what it should produce.
   task automatic send_frame(input logic [15:0] raw_l, input logic [15:0] raw_r,
                             input logic restart, input logic typed,
                             input out_type exp_l, input out_type exp_r);
      int            gap, n;
      out_frame_type f;
      gap = source_eager ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {raw_r, raw_l};
      req_tuser <= restart;
      do @(posedge clock); while (!req_tready);
      n_requests++;
      expand_frame(raw_l, raw_r, restart, n);
      if (typed) begin
         f.out_l = exp_l;
         f.out_r = exp_r;
         f.written = 1'b1;
         f.last = 1'b1;
         due_outputs.push_back(f);
      end else begin
         for (int i = 0; i < n; i++) due_outputs.push_back(burst[i]);
      end
   endtask

   // Stops offering, lets every expected result arrive, then lets the
   // pipeline settle so that frames with no output are finished too.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
      logic [31:0] expect_rd;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      n_writes++;
      case (idx)
         REG_GAIN: begin
            cfg_gain = value[GAIN_W-1:0];
            expect_rd = 32'(cfg_gain);
         end
         REG_MUTE_LEVEL: begin
            cfg_mute = value[MUTE_W-1:0];
            expect_rd = 32'(cfg_mute);
         end
         REG_STEP_SIZE: begin
            cfg_step = value[STEP_W-1:0];
            expect_rd = 32'(cfg_step);
         end
         REG_FORMAT: begin
            cfg_fmt = value[0];
            expect_rd = 32'(cfg_fmt);
         end
         REG_SRC_CH: begin
            cfg_src = value[CH_W-1:0];
            expect_rd = 32'(cfg_src);
         end
         REG_OUT_CH: begin
            cfg_out = value[CH_W-1:0];
            expect_rd = 32'(cfg_out);
         end
         default: begin
            expect_rd = '0;
         end
      endcase
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== expect_rd) begin
         n_errors++;
         $display("%0t: register %0d read back: expected %0h, actual %0h",
                  $time, idx, expect_rd, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random back-pressure and in-order comparison.
   initial begin : result_sink
      int            stall, eager, gap;
      out_frame_type want;
      out_frame_type got;
      stall = 0;
      eager = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_l = rsp_tdata[OUT_W-1:0];
            got.out_r = rsp_tdata[2*OUT_W-1:OUT_W];
            got.written = rsp_tuser;
            got.last = rsp_tlast;
            n_results++;
            if (!got.written) n_muted++;
            if (due_outputs.size() == 0) begin
               n_errors++;
               $display("%0t: result with nothing expected: L=%0d R=%0d wr=%0b last=%0b",
                        $time, got.out_l, got.out_r, got.written, got.last);
            end else begin
               want = due_outputs.pop_front();
               if (got !== want) begin
                  n_errors++;
                  $display("%0t: result mismatch: expected L=%0d R=%0d wr=%0b last=%0b, %s",
                           $time, want.out_l, want.out_r, want.written, want.last,
                           "see actual below");
                  $display("%0t:                  actual   L=%0d R=%0d wr=%0b last=%0b",
                           $time, got.out_l, got.out_r, got.written, got.last);
               end
            end
         end
         // Pick the ready level for the next edge.
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (eager > 0) begin
            eager--;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 3) begin
            eager = 80;
            rsp_tready <= 1'b1;
         end else begin
            gap = idle_len();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               stall = gap - 1;
               rsp_tready <= 1'b0;
            end
         end
         @(posedge clock);
      end
   end

   // Stimulus: reset, the directed table, then randomized phases.
   initial begin : stimulus
      int          waited;
      logic [31:0] ph_gain, ph_mute, ph_step, ph_fmt, ph_src, ph_out;
      logic [15:0] raw_l, raw_r;
      logic        restart;
      n_requests = 0;
      n_results = 0;
      n_muted = 0;
      n_writes = 0;
      n_errors = 0;
      source_eager = 1'b0;
      hold_off_request = 1'b0;
      cfg_gain = RST_GAIN;
      cfg_mute = RST_MUTE;
      cfg_step = RST_STEP;
      cfg_fmt = RST_FORMAT;
      cfg_src = CH_STEREO;
      cfg_out = CH_STEREO;
      hist_l = 0;
      hist_r = 0;
      src_pos = ONE_FRAME;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      for (int row = 0; row < DIR_ROWS; row++) begin
         if (DIRECTED[row].kind == ROW_WRITE) begin
            wait_idle();
            csr_write(DIRECTED[row].reg_idx, DIRECTED[row].value);
         end else begin
            send_frame(DIRECTED[row].raw_l, DIRECTED[row].raw_r, DIRECTED[row].restart,
                       DIRECTED[row].typed, DIRECTED[row].exp_l, DIRECTED[row].exp_r);
         end
      end

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               ph_gain = 32'(UNITY_GAIN);
               ph_mute = 32'(RST_MUTE);
               ph_step = 32'(RST_STEP);
               ph_fmt = 32'(FMT_S16);
               ph_src = 32'(CH_STEREO);
               ph_out = 32'(CH_STEREO);
            end
            1: begin
               ph_gain = 32'h00C0_0000;
               ph_mute = 32'd512;
               ph_step = 32'd4096;
               ph_fmt = 32'(FMT_U8);
               ph_src = 32'(CH_MONO);
               ph_out = 32'(CH_STEREO);
            end
            2: begin
               ph_gain = 32'(GAIN_LIMIT);
               ph_mute = 32'd0;
               ph_step = 32'd65536;
               ph_fmt = 32'(FMT_S16);
               ph_src = 32'(CH_STEREO);
               ph_out = 32'(CH_MONO);
            end
            3: begin
               ph_gain = 32'h1FFF_FFFF;
               ph_mute = 32'h01FF_FFFF;
               ph_step = 32'd0;
               ph_fmt = 32'(FMT_S16);
               ph_src = 32'd3;
               ph_out = 32'd0;
            end
            4: begin
               ph_gain = 32'd0;
               ph_mute = 32'd1;
               ph_step = 32'h1FFFF;
               ph_fmt = 32'(FMT_U8);
               ph_src = 32'd0;
               ph_out = 32'(CH_MONO);
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: ph_gain = 32'(UNITY_GAIN);
                  1: ph_gain = $urandom_range(0, 32'h0200_0000);
                  2: ph_gain = $urandom_range(0, 32'h1FFF_FFFF);
                  default: ph_gain = $urandom_range(32'(UNITY_GAIN), 32'(GAIN_LIMIT));
               endcase
               if ($urandom_range(0, 1) == 0) ph_mute = $urandom_range(0, 1024);
               else ph_mute = $urandom_range(0, 32'h01FF_FFFF);
               case ($urandom_range(0, 3))
                  0, 1: ph_step = $urandom_range(MIN_STEP, 16384);
                  2: ph_step = $urandom_range(0, MIN_STEP - 1);
                  default: ph_step = $urandom_range(16384, 32'h1FFFF);
               endcase
               ph_fmt = $urandom_range(0, 1);
               ph_src = $urandom_range(0, 3);
               ph_out = $urandom_range(0, 3);
            end
         endcase
         csr_write(REG_GAIN, ph_gain);
         csr_write(REG_MUTE_LEVEL, ph_mute);
         csr_write(REG_STEP_SIZE, ph_step);
         csr_write(REG_FORMAT, ph_fmt);
         csr_write(REG_SRC_CH, ph_src);
         csr_write(REG_OUT_CH, ph_out);
         source_eager = ($urandom_range(0, 3) == 0);
         // First phase: the result side holds off while requests keep coming.
         if (phase == 0) begin
            source_eager = 1'b1;
            hold_off_request = 1'b1;
         end
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // Once in the run the source pauses until the output side is empty.
            if (phase == 5 && item == PHASE_ITEMS / 2) wait_idle();
            raw_l = rand_sample();
            raw_r = rand_sample();
            restart = ($urandom_range(0, 19) == 0);
            send_frame(raw_l, raw_r, restart, 1'b0, '0, '0);
         end
      end

      // Drain and report.
      req_tvalid <= 1'b0;
      waited = 0;
      while (due_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_outputs.size() != 0) begin
         n_errors++;
         $display("%0t: %0d expected results never arrived", $time, due_outputs.size());
      end
      $display("Run covered %0d source requests and %0d output frames (%0d muted),",
               n_requests, n_results, n_muted);
      $display("with %0d register writes across directed and random settings.", n_writes);
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d errors found", n_errors);
         $display("tb: failure");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin : watchdog
      #30_000_000;
      $display("%0t: run did not complete in time", $time);
      $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/lir_pkg.sv
hw/rtl/lir_seq.sv
hw/rtl/lir_lane.sv
hw/rtl/lir_merge.sv
hw/rtl/linear_interp_resampler_top.sv
tb/tb_linear_interp_resampler_top.sv
